// ----- rtl/core/bfa_pkg.sv -----
package bfa_pkg;

    // operand class decided by the front part
    typedef enum logic [2:0] {
        CLS_NAN = 3'b001,
        CLS_INF = 3'b010,
        CLS_FIN = 3'b100
    } cls_t;

    // classified item carried from the front part to the back part
    typedef struct packed {
        logic        special;   // result fully decided in front
        logic [15:0] special_value;
        logic        sa;        // sign of the larger magnitude
        logic        sb;
        logic [7:0]  ea;        // larger exponent (subnormal as 1)
        logic [7:0]  d;         // exponent difference
        logic [7:0]  ma;        // significand with hidden bit
        logic [7:0]  mb;
        logic        last;
    } front_item_t;

    localparam logic [15:0] DEFAULT_NAN16 = 16'hFFC0;
    localparam logic [15:0] QUIET16 = 16'h0040;

endpackage

// ----- rtl/core/bfa_front.sv -----
module bfa_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [15:0]          acc_value,
    input  logic [15:0]          in_value,
    input  logic                 last_in,
    output logic                 q_valid,
    input  logic                 q_stall,
    output bfa_pkg::front_item_t q_item
);
    import bfa_pkg::*;

    cls_t        cls_a;
    cls_t        cls_b;
    front_item_t item;
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [7:0]  ma;
    logic [7:0]  mb;
    logic        swap;
    logic        valid_reg;
    front_item_t item_reg;

    function automatic cls_t classify(input logic [15:0] v);
        if (v[14:7] == 8'hFF)
        begin
            return (v[6:0] != 7'd0) ? CLS_NAN : CLS_INF;
        end
        return CLS_FIN;
    endfunction

    always_comb
    begin
        cls_a = classify(acc_value);
        cls_b = classify(in_value);
        ea = (acc_value[14:7] == 8'd0) ? 8'd1 : acc_value[14:7];
        eb = (in_value[14:7] == 8'd0) ? 8'd1 : in_value[14:7];
        ma = {acc_value[14:7] != 8'd0, acc_value[6:0]};
        mb = {in_value[14:7] != 8'd0, in_value[6:0]};
        swap = (eb > ea) || ((eb == ea) && (mb > ma));
        item = '0;
        item.last = last_in;
        if (cls_a == CLS_NAN)
        begin
            item.special = 1'b1;
            item.special_value = acc_value | QUIET16;
        end
        else if (cls_b == CLS_NAN)
        begin
            item.special = 1'b1;
            item.special_value = in_value | QUIET16;
        end
        else if (cls_a == CLS_INF)
        begin
            item.special = 1'b1;
            item.special_value = (cls_b == CLS_INF && acc_value[15] != in_value[15])
                ? DEFAULT_NAN16 : acc_value;
        end
        else if (cls_b == CLS_INF)
        begin
            item.special = 1'b1;
            item.special_value = in_value;
        end
        if (swap)
        begin
            item.sa = in_value[15];
            item.sb = acc_value[15];
            item.ea = eb;
            item.d  = eb - ea;
            item.ma = mb;
            item.mb = ma;
        end
        else
        begin
            item.sa = acc_value[15];
            item.sb = in_value[15];
            item.ea = ea;
            item.d  = ea - eb;
            item.ma = ma;
            item.mb = mb;
        end
    end

    assign in_stall = valid_reg && q_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= item;
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

// ----- rtl/core/bfa_queue.sv -----
module bfa_queue #(
    parameter int Depth = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_stall,
    input  bfa_pkg::front_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_stall,
    output bfa_pkg::front_item_t rd_item
);
    import bfa_pkg::*;

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    front_item_t         mem_reg [Depth];
    logic [AW-1:0]       wr_ptr_reg;
    logic [AW-1:0]       rd_ptr_reg;
    logic [AW:0]         count_reg;
    logic                push;
    logic                pop;

    assign wr_stall = (count_reg == (AW+1)'(Depth));
    assign rd_valid = (count_reg != '0);
    assign push = wr_valid && !wr_stall;
    assign pop  = rd_valid && !rd_stall;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(Depth)) else $error("queue overflow");
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == (AW+1)'(Depth)) |-> wr_stall) else $error("full queue not stalling");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("count did not advance");

endmodule

// ----- rtl/core/bfa_back.sv -----
module bfa_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_stall,
    input  bfa_pkg::front_item_t q_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [15:0]          sum_value,
    output logic                 last_out
);
    import bfa_pkg::*;

    // stage 1: align and add; stage 2: normalize, round, narrow
    logic        s1_valid_reg;
    logic        s1_special_reg;
    logic [15:0] s1_special_value_reg;
    logic        s1_sgn_reg;
    logic        s1_zsign_reg;
    logic [7:0]  s1_e_reg;
    logic [27:0] s1_sum_reg;
    logic        s1_last_reg;
    logic        s2_valid_reg;
    logic [15:0] s2_value_reg;
    logic        s2_last_reg;

    logic        adv2;
    logic        adv1;
    logic [26:0] xa;
    logic [26:0] xb;
    logic [26:0] sh;
    logic        sticky;
    logic [27:0] sum;

    logic [27:0] ns;
    logic [8:0]  ne;
    logic [4:0]  lz;
    logic [4:0]  shamt;
    logic [2:0]  low;
    logic [24:0] m;
    logic [31:0] f32;
    logic [15:0] hi;
    logic [15:0] result;

    assign adv2 = !s2_valid_reg || !out_stall;
    assign adv1 = !s1_valid_reg || adv2;
    assign q_stall = !adv1;

    // operands widened to binary32 significands with three guard bits
    always_comb
    begin
        xa = {q_item.ma, 19'd0};
        xb = {q_item.mb, 19'd0};
        sticky = 1'b0;
        if (q_item.d >= 8'd32)
        begin
            sh = 27'(xb != 27'd0);
        end
        else
        begin
            for (int i = 0; i < 27; i++)
            begin
                if (i < int'(q_item.d) && xb[i])
                begin
                    sticky = 1'b1;
                end
            end
            sh = (xb >> q_item.d[4:0]) | 27'(sticky);
        end
        sum = (q_item.sa == q_item.sb) ? ({1'b0, xa} + {1'b0, sh})
                                       : ({1'b0, xa} - {1'b0, sh});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= q_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && q_valid)
        begin
            s1_special_reg       <= q_item.special;
            s1_special_value_reg <= q_item.special_value;
            s1_sgn_reg           <= q_item.sa;
            s1_zsign_reg         <= q_item.sa & q_item.sb;
            s1_e_reg             <= q_item.ea;
            s1_sum_reg           <= sum;
            s1_last_reg          <= q_item.last;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_value_reg <= result;
            s2_last_reg  <= s1_last_reg;
        end
    end

    // normalize: sum fits in 28 bits, leading one targeted at bit 26
    always_comb
    begin
        ns = s1_sum_reg;
        ne = {1'b0, s1_e_reg};
        if (ns[27])
        begin
            ns = {1'b0, ns[27:2], ns[1] | ns[0]};
            ne = ne + 9'd1;
        end
        lz = 5'd0;
        for (int i = 0; i <= 26; i++)
        begin
            if (ns[i])
            begin
                lz = 5'(26 - i);
            end
        end
        shamt = (9'(lz) < ne) ? lz : 5'(ne - 9'd1);
        ns = ns << shamt;
        ne = ne - 9'(shamt);
        low = ns[2:0];
        m = {1'b0, ns[26:3]};
        if (low > 3'd4 || (low == 3'd4 && m[0]))
        begin
            m = m + 25'd1;
        end
        if (m[24])
        begin
            m = m >> 1;
            ne = ne + 9'd1;
        end
        if (!m[23])
        begin
            ne = 9'd0;
        end
        f32 = {s1_sgn_reg, ne[7:0], m[22:0]};
        if (ne >= 9'd255)
        begin
            f32 = {s1_sgn_reg, 8'hFF, 23'd0};
        end
        // narrow: round half up on the magnitude, wraps in 16 bits
        hi = f32[31:16] + {15'd0, f32[15]};
        if (s1_special_reg)
        begin
            result = s1_special_value_reg;
        end
        else if (s1_sum_reg == 28'd0)
        begin
            result = {s1_zsign_reg, 15'd0};
        end
        else
        begin
            result = hi;
        end
    end

    assign out_valid = s2_valid_reg;
    assign sum_value = s2_value_reg;
    assign last_out  = s2_last_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && out_stall) |=> (s2_valid_reg && $stable(s2_value_reg)))
        else $error("result changed under stall");
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_stall |-> (s1_valid_reg && s2_valid_reg)) else $error("back stalled with room");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && adv2) |=> s2_valid_reg) else $error("stage 1 item lost");

endmodule

// ----- rtl/core/bfloat16_adder.sv -----
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | acc_value, in_value, last_in
// output  | out_valid | out_stall | sum_value, last_out
//
// one transaction per cycle sustained while out_stall is low; each result passes the
// front register, the queue, the add stage and the round stage in order
// rst_n clears all valid state asynchronously; payload registers are not reset
// the queue of QueueDepth entries lets the front keep taking transactions while
// the output is stalled; in_stall rises only when all stages are full
module bfloat16_adder #(
    parameter int QueueDepth = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] acc_value,
    input  logic [15:0] in_value,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] sum_value,
    output logic        last_out
);
    import bfa_pkg::*;

    logic        f_valid;
    logic        f_stall;
    front_item_t f_item;
    logic        b_valid;
    logic        b_stall;
    front_item_t b_item;

    // front: classify operands and order by magnitude
    bfa_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .acc_value (acc_value),
        .in_value  (in_value),
        .last_in   (last_in),
        .q_valid   (f_valid),
        .q_stall   (f_stall),
        .q_item    (f_item)
    );

    // decoupling queue between front and back
    bfa_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_stall (f_stall),
        .wr_item  (f_item),
        .rd_valid (b_valid),
        .rd_stall (b_stall),
        .rd_item  (b_item)
    );

    // back: add, normalize, round, narrow
    bfa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (b_valid),
        .q_stall   (b_stall),
        .q_item    (b_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum_value (sum_value),
        .last_out  (last_out)
    );

endmodule

// ----- tb/tb_top.sv -----
module tb_top;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] acc_value;
    logic [15:0] in_value;
    logic        last_in;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] sum_value;
    logic        last_out;

    localparam int LATENCY = 4;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [31:0] QUIET32 = 32'h0040_0000;
    localparam logic [31:0] DEFAULT_NAN32 = 32'hFFC0_0000;
    localparam logic [31:0] INF32 = 32'h7F80_0000;

    // expected sum and last mark, packed as {last, sum}
    logic [16:0] sum_queue[$];
    int          mismatches;
    int          sent;
    int          received;
    int          idle_cycles;
    int          nan_items;
    int          inf_items;
    int          stall_mode;

    bfloat16_adder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .acc_value (acc_value),
        .in_value  (in_value),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum_value (sum_value),
        .last_out  (last_out)
    );

    always #10 clk = ~clk;

    function automatic logic is_nan32(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] != 0;
    endfunction

    function automatic logic is_inf32(logic [31:0] x);
        return x[30:23] == 8'hFF && x[22:0] == 0;
    endfunction

    // binary32 add, round to nearest even, on bit patterns
    function automatic logic [31:0] fp32_add(logic [31:0] a, logic [31:0] b);
        logic        sa;
        logic        sb;
        logic        t;
        logic [8:0]  ea;
        logic [8:0]  eb;
        logic [8:0]  e;
        logic [8:0]  dd;
        logic [23:0] ma;
        logic [23:0] mb;
        logic [23:0] tm;
        logic [8:0]  te;
        logic [31:0] m;
        logic [63:0] xa;
        logic [63:0] xb;
        logic [63:0] s;
        logic [63:0] lost;
        sa = a[31];
        sb = b[31];
        if (is_nan32(a)) return a | QUIET32;
        if (is_nan32(b)) return b | QUIET32;
        if (is_inf32(a))
        begin
            if (is_inf32(b) && sa != sb) return DEFAULT_NAN32;
            return a;
        end
        if (is_inf32(b)) return b;
        ea = {1'b0, a[30:23]};
        eb = {1'b0, b[30:23]};
        ma = {1'b0, a[22:0]};
        mb = {1'b0, b[22:0]};
        if (ea == 0) ea = 1; else ma[23] = 1'b1;
        if (eb == 0) eb = 1; else mb[23] = 1'b1;
        // larger magnitude goes to a
        if (eb > ea || (eb == ea && mb > ma))
        begin
            te = ea; ea = eb; eb = te;
            tm = ma; ma = mb; mb = tm;
            t = sa; sa = sb; sb = t;
        end
        xa = 64'(ma) << 3;
        xb = 64'(mb) << 3;
        dd = ea - eb;
        if (dd >= 32)
            xb = (xb != 0) ? 64'd1 : 64'd0;
        else if (dd > 0)
        begin
            lost = xb & ((64'd1 << dd) - 1);
            xb = (xb >> dd) | ((lost != 0) ? 64'd1 : 64'd0);
        end
        s = (sa == sb) ? xa + xb : xa - xb;
        if (s == 0) return {sa & sb, 31'd0};
        e = ea;
        if (s >= (64'd1 << 27))
        begin
            s = (s >> 1) | (s & 64'd1);
            e++;
        end
        while (s < (64'd1 << 26) && e > 1)
        begin
            s = s << 1;
            e--;
        end
        if (e >= 255) return {sa, 31'd0} | INF32;
        m = s[34:3];
        if (s[2:0] > 4 || (s[2:0] == 4 && m[0])) m++;
        if (m >= (32'd1 << 24))
        begin
            m = m >> 1;
            e++;
        end
        if (e >= 255) return {sa, 31'd0} | INF32;
        if (!m[23]) e = 0;
        return {sa, e[7:0], m[22:0]};
    endfunction

    // widen, add, narrow with half-up increment that wraps in 16 bits
    function automatic logic [15:0] bf16_sum(logic [15:0] a, logic [15:0] b);
        logic [31:0] u;
        u = fp32_add({a, 16'h0}, {b, 16'h0});
        return u[31:16] + {15'd0, u[15]};
    endfunction

    task automatic report_mismatch(string what, logic [16:0] got, logic [16:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // one transaction, with an idle gap before it when gap is positive
    task automatic send_item(logic [15:0] a, logic [15:0] b, logic last, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        acc_value <= a;
        in_value  <= b;
        last_in   <= last;
        sum_queue.push_back({last, bf16_sum(a, b)});
        if (bf16_sum(a, b) ==? 16'b?111_1111_1???_????) inf_items++;
        if (a[14:7] == 8'hFF || b[14:7] == 8'hFF) nan_items++;
        sent++;
        // wait for acceptance at a later edge
        do @(posedge clk); while (in_stall);
    endtask

    // random gap drawn for bursts: mostly none, sometimes long
    function automatic int burst_gap();
        if ($urandom_range(0, 9) < 7) return 0;
        return $urandom_range(1, 6);
    endfunction

    // value generator biased toward exponent extremes
    function automatic logic [15:0] rand_bf16();
        logic [15:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: v[14:7] = 8'hFF;
            1: v[14:7] = 8'h00;
            2: v[14:7] = 8'hFE;
            default: ;
        endcase
        return v;
    endfunction

    // result checker against the oldest expected transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            received++;
            if (sum_queue.size() == 0)
                report_mismatch("unexpected", {last_out, sum_value}, 17'h0);
            else
            begin
                logic [16:0] want;
                want = sum_queue.pop_front();
                if (sum_value !== want[15:0])
                    report_mismatch("sum_value", {1'b0, sum_value}, {1'b0, want[15:0]});
                if (last_out !== want[16])
                    report_mismatch("last_out", {16'd0, last_out}, {16'd0, want[16]});
            end
        end
    end

    // receiver stall pattern: off, bursty, or heavy
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no progress, %0d outstanding", sum_queue.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sum_queue.size() != 0) @(posedge clk);
    endtask

    // extremes of exponent, signs, nan/inf and zero cases
    task automatic test_directed();
        logic [15:0] vals[12];
        vals = '{16'h0000, 16'h8000, 16'h7F80, 16'hFF80, 16'h7FC1, 16'hFF81,
                 16'h0001, 16'h807F, 16'h7F7F, 16'hFF7F, 16'h3F80, 16'hFFFF};
        send_item(16'h7F80, 16'hFF80, 1'b0, 0);  // opposite infinities
        send_item(16'h8000, 16'h8000, 1'b1, 0);  // two negative zeros
        send_item(16'h3F80, 16'hBF80, 1'b0, 0);  // exact cancellation
        send_item(16'h7F7F, 16'h7F7F, 1'b1, 0);  // overflow
        send_item(16'h7F81, 16'h7FC0, 1'b0, 0);  // signaling nan first
        send_item(16'h0000, 16'hFF81, 1'b1, 0);  // nan in second operand
        send_item(16'hFFFF, 16'h0000, 1'b0, 0);  // negative nan, all payload bits set
        send_item(16'h3F80, 16'h3B80, 1'b0, 0);  // exact half rounds up
        for (int i = 0; i < 12; i++)
            send_item(vals[i], vals[(i * 5 + 3) % 12], i[0], 0);
    endtask

    // random operands, varying stall patterns
    task automatic test_random(int count, int mode);
        stall_mode = mode;
        for (int i = 0; i < count; i++)
            send_item(rand_bf16(), rand_bf16(), 1'($urandom), burst_gap());
    endtask

    // sender holds off until every result has arrived, then resumes under heavy stalls
    task automatic test_drain_pause();
        wait_drained();
        repeat (LATENCY + 2) @(posedge clk);
        test_random(50, 2);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        acc_value = 16'h0;
        in_value = 16'h0;
        last_in = 1'b0;
        out_stall = 1'b0;
        stall_mode = 0;
        mismatches = 0;
        sent = 0;
        received = 0;
        idle_cycles = 0;
        nan_items = 0;
        inf_items = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        stall_mode = 1;
        test_directed();
        test_random(500, 0);
        test_drain_pause();
        test_random(500, 1);
        test_random(500, 2);
        wait_drained();
        stall_mode = 0;
        repeat (LATENCY * 4) @(posedge clk);
        $display("sent %0d transactions, checked %0d sums", sent, received);
        $display("items with nan/inf operands %0d, inf/nan sums %0d", nan_items, inf_items);
        if (mismatches == 0 && sum_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
